FILE: sv/sqvs_pkg.sv
// sqvs_pkg: types, constants and helper functions for the sprite quad vertex setup block
// no dependencies; imported by every module of the block

package sqvs_pkg;

	// angle reduction: Q12.4 degrees, full turn is 5760 units
	localparam int ANG_FULL   = 5760;
	localparam int ANG_QUART  = 1440;
	localparam int ANG_EIGHTH = 720;
	// bias that makes any 16 bit angle positive, a multiple of the full turn
	localparam int ANG_BIAS   = 207360;
	// floor(2^23 / 5760), quotient estimate is low by at most one
	localparam int ANG_RECIP  = 1456;
	localparam int ANG_SHIFT  = 23;

	localparam longint RAD_Q30 = 1171271;
	localparam longint ONE_Q30 = 64'd1073741824;

	localparam int OPACITY_ONE = 16384;
	localparam int POS_MAX     = 8388607;
	localparam int POS_MIN     = -8388608;

	// divider: four quotient bits per cycle, sixteen bits in all
	localparam int DIV_STEPS  = 4;
	localparam int DIV_CYCLES = 4;

	// compute phases: load, products, sums, then wait for dividers
	localparam logic [2:0] PH_PROD = 3'd1;
	localparam logic [2:0] PH_SUM  = 3'd2;
	localparam logic [2:0] PH_DONE = 3'd5;

	localparam logic [2:0] VTX_LAST = 3'd5;

	localparam int SQVS_FIFO_DEPTH = 4;

	typedef enum logic [1:0] {
		CORNER_TL = 2'd0,
		CORNER_TR = 2'd1,
		CORNER_BL = 2'd2,
		CORNER_BR = 2'd3
	} sqvs_corner_t;

	typedef struct packed {
		logic signed [23:0] center_x;
		logic signed [23:0] center_y;
		logic signed [23:0] sprite_width;
		logic signed [23:0] sprite_height;
		logic signed [15:0] rotation_deg;
		logic signed [15:0] opacity_in;
		logic        [7:0]  effect_code;
		logic        [31:0] texture_size;
		logic        [23:0] src_left;
		logic        [23:0] src_top;
		logic        [23:0] src_right;
		logic        [23:0] src_bottom;
	} sqvs_sprite_t;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic        [15:0] tex_u;
		logic        [15:0] tex_v;
		logic        [14:0] vertex_opacity;
		logic        [7:0]  vertex_effect;
		logic               last_vertex;
	} sqvs_vertex_t;

	// classified sprite, queued between front and back
	typedef struct packed {
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic signed [23:0] w;
		logic signed [23:0] h;
		logic        [1:0]  quad;
		logic               swap;
		logic        [9:0]  off;
		logic        [14:0] opc;
		logic        [7:0]  eff;
		logic        [15:0] tw;
		logic        [15:0] th;
		logic        [23:0] el;
		logic        [23:0] et;
		logic        [23:0] er;
		logic        [23:0] eb;
	} sqvs_job_t;

	// corner terms of one sprite, Q39, plus per sprite attributes
	typedef struct packed {
		logic signed [57:0] xp;
		logic signed [57:0] xm;
		logic signed [57:0] a;
		logic signed [57:0] yp;
		logic signed [57:0] ym;
		logic signed [57:0] c;
		logic        [15:0] u0;
		logic        [15:0] u1;
		logic        [15:0] v0;
		logic        [15:0] v1;
		logic        [14:0] opc;
		logic        [7:0]  eff;
	} sqvs_quad_t;

	// sin in the upper half, cos in the lower half, Q30, 0..45 degrees
	typedef logic [61:0] sqvs_sc_rom_t [0:ANG_EIGHTH];

	function automatic sqvs_sc_rom_t sc_rom_build();
		sqvs_sc_rom_t t;
		logic [63:0] r, r2, r3, r4, r5, r6, r7, r8, r9, s, c;
		for (int u = 0; u <= ANG_EIGHTH; u++) begin
			r  = 64'(u) * 64'(RAD_Q30);
			r2 = (r * r) >> 30;
			r3 = (r2 * r) >> 30;
			r4 = (r2 * r2) >> 30;
			r5 = (r4 * r) >> 30;
			r6 = (r4 * r2) >> 30;
			r7 = (r6 * r) >> 30;
			r8 = (r4 * r4) >> 30;
			r9 = (r8 * r) >> 30;
			s  = r - r3 / 64'd6 + r5 / 64'd120 - r7 / 64'd5040 + r9 / 64'd362880;
			c  = ONE_Q30 - r2 / 64'd2 + r4 / 64'd24 - r6 / 64'd720 + r8 / 64'd40320;
			t[u] = {s[30:0], c[30:0]};
		end
		return t;
	endfunction

	// vertex order TL TR BL, TR BR BL
	function automatic sqvs_corner_t corner_of(input logic [2:0] k);
		sqvs_corner_t cn;
		unique case (k)
			3'd0:    cn = CORNER_TL;
			3'd1:    cn = CORNER_TR;
			3'd2:    cn = CORNER_BL;
			3'd3:    cn = CORNER_TR;
			3'd4:    cn = CORNER_BR;
			default: cn = CORNER_BL;
		endcase
		return cn;
	endfunction

	// Q39 to Q8, round half up, saturate to 24 bits
	function automatic logic signed [23:0] pos_round(input logic signed [57:0] v);
		logic signed [57:0] b;
		logic signed [26:0] t;
		logic signed [23:0] r;
		b = v + 58'sd1073741824;
		t = 27'(b >>> 31);
		if (t > 27'sd8388607)
			r = 24'(POS_MAX);
		else if (t < -27'sd8388608)
			r = 24'(POS_MIN);
		else
			r = t[23:0];
		return r;
	endfunction

endpackage

FILE: sv/sqvs_front.sv
// sqvs_front: accepts sprites, drops undrawable ones, reduces the angle
// depends on sqvs_pkg

module sqvs_front import sqvs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         sprite_valid,
	output logic         sprite_stall,
	input  sqvs_sprite_t sprite,
	output logic         push,
	output sqvs_job_t    job,
	input  logic         full
);

	logic        keep;
	logic        empty_rect;
	logic [18:0] ang_b;
	logic [28:0] ang_prod;
	logic        valid_s1;
	sqvs_job_t   job_s1;
	logic [17:0] x_s1;
	logic [5:0]  q0_s1;
	logic [17:0] m0;
	logic [12:0] m;
	logic [1:0]  quad;
	logic [10:0] f;

	assign keep = (sprite.sprite_width > 24'sd0) && (sprite.sprite_height > 24'sd0)
		&& (sprite.opacity_in > 16'sd0);
	assign empty_rect = (sprite.src_right <= sprite.src_left)
		|| (sprite.src_bottom <= sprite.src_top);
	assign ang_b    = 19'($signed(sprite.rotation_deg)) + 19'(ANG_BIAS);
	assign ang_prod = 29'(ang_b[17:0]) * 29'(ANG_RECIP);

	assign sprite_stall = valid_s1 & full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sprite_stall) begin
			valid_s1 <= sprite_valid & keep;
		end
	end

	always_ff @(posedge clk) begin
		if (!sprite_stall) begin
			x_s1       <= ang_b[17:0];
			q0_s1      <= ang_prod[28:23];
			job_s1.cx  <= sprite.center_x;
			job_s1.cy  <= sprite.center_y;
			job_s1.w   <= sprite.sprite_width;
			job_s1.h   <= sprite.sprite_height;
			job_s1.quad <= 2'd0;
			job_s1.swap <= 1'b0;
			job_s1.off <= 10'd0;
			job_s1.opc <= (sprite.opacity_in > 16'sd16384) ? 15'(OPACITY_ONE)
				: sprite.opacity_in[14:0];
			job_s1.eff <= sprite.effect_code;
			job_s1.tw  <= sprite.texture_size[15:0];
			job_s1.th  <= sprite.texture_size[31:16];
			if (empty_rect) begin
				job_s1.el <= 24'd0;
				job_s1.et <= 24'd0;
				job_s1.er <= {sprite.texture_size[15:0], 8'd0};
				job_s1.eb <= {sprite.texture_size[31:16], 8'd0};
			end else begin
				job_s1.el <= sprite.src_left;
				job_s1.et <= sprite.src_top;
				job_s1.er <= sprite.src_right;
				job_s1.eb <= sprite.src_bottom;
			end
		end
	end

	// angle mod full turn, then quadrant and octant offset
	assign m0 = x_s1 - 18'(18'(q0_s1) * 18'(ANG_FULL));
	assign m  = (m0 >= 18'(ANG_FULL)) ? 13'(m0 - 18'(ANG_FULL)) : m0[12:0];

	always_comb begin
		if (m >= 13'(3 * ANG_QUART))
			quad = 2'd3;
		else if (m >= 13'(2 * ANG_QUART))
			quad = 2'd2;
		else if (m >= 13'(ANG_QUART))
			quad = 2'd1;
		else
			quad = 2'd0;
		f = 11'(m - 13'(13'(quad) * 13'(ANG_QUART)));
		job = job_s1;
		job.quad = quad;
		job.swap = (f > 11'(ANG_EIGHTH));
		job.off  = (f > 11'(ANG_EIGHTH)) ? 10'(11'(ANG_QUART) - f) : f[9:0];
	end

	assign push = valid_s1 & !full;

endmodule

FILE: sv/sqvs_fifo.sv
// sqvs_fifo: short queue of classified sprites between front and back
// depends on sqvs_pkg

module sqvs_fifo import sqvs_pkg::*; #(
	parameter int DEPTH = SQVS_FIFO_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  sqvs_job_t din,
	output logic      full,
	input  logic      pop,
	output sqvs_job_t dout,
	output logic      nonempty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sqvs_job_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign dout     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

endmodule

FILE: sv/sqvs_div.sv
// sqvs_div: iterative uv divider, four quotient bits a cycle, saturating at 65535
// depends on sqvs_pkg

module sqvs_div import sqvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] num,
	input  logic [15:0] den,
	output logic [15:0] quo
);

	logic [2:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] sh_q;
	logic [15:0] quo_q;
	logic [15:0] den_q;
	logic [15:0] lo_q;
	logic        sat_q;
	logic        zero_q;
	logic        sat;
	logic [15:0] rem_n;
	logic [15:0] sh_n;
	logic [15:0] quo_n;

	assign sat = (den == 16'd0) ? (num > 31'd65535) : ({1'b0, num} >= {den, 16'd0});

	always_comb begin
		logic [16:0] r17;
		rem_n = rem_q;
		sh_n  = sh_q;
		quo_n = quo_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			r17  = {rem_n, sh_n[15]};
			sh_n = {sh_n[14:0], 1'b0};
			if (r17 >= {1'b0, den_q}) begin
				rem_n = 16'(r17 - {1'b0, den_q});
				quo_n = {quo_n[14:0], 1'b1};
			end else begin
				rem_n = r17[15:0];
				quo_n = {quo_n[14:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (start)
			cnt_q <= 3'(DIV_CYCLES);
		else if (cnt_q != '0)
			cnt_q <= cnt_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num[30:16]};
			sh_q   <= num[15:0];
			quo_q  <= '0;
			den_q  <= den;
			lo_q   <= num[15:0];
			sat_q  <= sat;
			zero_q <= (den == 16'd0);
		end else if (cnt_q != '0) begin
			rem_q <= rem_n;
			sh_q  <= sh_n;
			quo_q <= quo_n;
		end
	end

	assign quo = sat_q ? 16'hFFFF : (zero_q ? lo_q : quo_q);

endmodule

FILE: sv/sqvs_calc.sv
// sqvs_calc: per sprite sin/cos lookup, corner products and uv division
// depends on sqvs_pkg and sqvs_div

module sqvs_calc import sqvs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  sqvs_job_t  job,
	output logic       job_pop,
	output logic       quad_valid,
	output sqvs_quad_t quad,
	input  logic       quad_take
);

	localparam sqvs_sc_rom_t SC_ROM = sc_rom_build();

	logic               busy_q;
	logic [2:0]         ph_q;
	logic               load;
	sqvs_job_t          job_q;
	logic [61:0]        rom_q;
	logic [30:0]        s0;
	logic [30:0]        c0;
	logic signed [31:0] sn;
	logic signed [31:0] cs;
	logic signed [55:0] a_q, b_q, c_q, d_q;
	logic signed [57:0] xp_q, xm_q, yp_q, ym_q;
	logic signed [54:0] cxq, cyq;
	logic [15:0]        u0, u1, v0, v1;

	assign load    = job_valid & (!busy_q | quad_take);
	assign job_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			ph_q   <= PH_PROD;
		end else if (quad_take) begin
			busy_q <= 1'b0;
		end else if (busy_q && ph_q != PH_DONE) begin
			ph_q <= ph_q + 1'b1;
		end
	end

	// octant swap, then quadrant rotation
	assign s0 = job_q.swap ? rom_q[30:0] : rom_q[61:31];
	assign c0 = job_q.swap ? rom_q[61:31] : rom_q[30:0];

	always_comb begin
		case (job_q.quad)
			2'd0: begin
				sn = $signed({1'b0, s0});
				cs = $signed({1'b0, c0});
			end
			2'd1: begin
				sn = $signed({1'b0, c0});
				cs = -$signed({1'b0, s0});
			end
			2'd2: begin
				sn = -$signed({1'b0, s0});
				cs = -$signed({1'b0, c0});
			end
			default: begin
				sn = -$signed({1'b0, c0});
				cs = $signed({1'b0, s0});
			end
		endcase
	end

	assign cxq = $signed({job_q.cx, 31'd0});
	assign cyq = $signed({job_q.cy, 31'd0});

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
			rom_q <= SC_ROM[job.off];
		end
		if (busy_q && ph_q == PH_PROD) begin
			a_q <= $signed(job_q.w) * cs;
			b_q <= $signed(job_q.h) * sn;
			c_q <= $signed(job_q.w) * sn;
			d_q <= $signed(job_q.h) * cs;
		end
		if (busy_q && ph_q == PH_SUM) begin
			xp_q <= 58'(cxq) + 58'(b_q);
			xm_q <= 58'(cxq) - 58'(b_q);
			yp_q <= 58'(cyq) + 58'(d_q);
			ym_q <= 58'(cyq) - 58'(d_q);
		end
	end

	sqvs_div u_div_u0 (
		.clk(clk), .arst_n(arst_n), .start(load),
		.num(31'({job.el, 6'd0}) + 31'(job.tw[15:1])), .den(job.tw), .quo(u0)
	);
	sqvs_div u_div_u1 (
		.clk(clk), .arst_n(arst_n), .start(load),
		.num(31'({job.er, 6'd0}) + 31'(job.tw[15:1])), .den(job.tw), .quo(u1)
	);
	sqvs_div u_div_v0 (
		.clk(clk), .arst_n(arst_n), .start(load),
		.num(31'({job.et, 6'd0}) + 31'(job.th[15:1])), .den(job.th), .quo(v0)
	);
	sqvs_div u_div_v1 (
		.clk(clk), .arst_n(arst_n), .start(load),
		.num(31'({job.eb, 6'd0}) + 31'(job.th[15:1])), .den(job.th), .quo(v1)
	);

	assign quad_valid = busy_q && (ph_q == PH_DONE);

	always_comb begin
		quad.xp  = xp_q;
		quad.xm  = xm_q;
		quad.a   = 58'(a_q);
		quad.yp  = yp_q;
		quad.ym  = ym_q;
		quad.c   = 58'(c_q);
		quad.u0  = u0;
		quad.u1  = u1;
		quad.v0  = v0;
		quad.v1  = v1;
		quad.opc = job_q.opc;
		quad.eff = job_q.eff;
	end

endmodule

FILE: sv/sqvs_emit.sv
// sqvs_emit: walks the six vertices of a sprite into the output register
// depends on sqvs_pkg

module sqvs_emit import sqvs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         quad_valid,
	input  sqvs_quad_t   quad,
	output logic         ready,
	output logic         vertex_valid,
	input  logic         vertex_stall,
	output sqvs_vertex_t vertex
);

	sqvs_quad_t         quad_q;
	logic               has_q;
	logic [2:0]         vidx_q;
	logic               adv;
	logic               take;
	sqvs_corner_t       cn;
	logic signed [57:0] xb, yb, xv, yv;

	assign adv   = has_q & (!vertex_valid | !vertex_stall);
	assign ready = !has_q | (adv & (vidx_q == VTX_LAST));
	assign take  = ready & quad_valid;

	assign cn = corner_of(vidx_q);
	assign xb = cn[1] ? quad_q.xm : quad_q.xp;
	assign yb = cn[1] ? quad_q.yp : quad_q.ym;
	assign xv = cn[0] ? xb + quad_q.a : xb - quad_q.a;
	assign yv = cn[0] ? yb + quad_q.c : yb - quad_q.c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_q        <= 1'b0;
			vidx_q       <= '0;
			vertex_valid <= 1'b0;
		end else begin
			if (take) begin
				has_q  <= 1'b1;
				vidx_q <= '0;
			end else if (adv) begin
				if (vidx_q == VTX_LAST)
					has_q <= 1'b0;
				vidx_q <= vidx_q + 1'b1;
			end
			if (adv)
				vertex_valid <= 1'b1;
			else if (!vertex_stall)
				vertex_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			quad_q <= quad;
		if (adv) begin
			vertex.pos_x          <= pos_round(xv);
			vertex.pos_y          <= pos_round(yv);
			vertex.tex_u          <= cn[0] ? quad_q.u1 : quad_q.u0;
			vertex.tex_v          <= cn[1] ? quad_q.v1 : quad_q.v0;
			vertex.vertex_opacity <= quad_q.opc;
			vertex.vertex_effect  <= quad_q.eff;
			vertex.last_vertex    <= (vidx_q == VTX_LAST);
		end
	end

endmodule

FILE: sv/sprite_quad_vertex_setup.sv
// sprite_quad_vertex_setup: top level, turns rotated sprites into triangle list vertices
// depends on sqvs_pkg, sqvs_front, sqvs_fifo, sqvs_calc, sqvs_emit
//
// usage
//  - sprite channel: one item is a whole sprite, taken when sprite_valid is high
//    and sprite_stall low; sprites with non-positive size or opacity are taken
//    and dropped without output
//  - vertex channel: six items per drawn sprite, TL TR BL then TR BR BL,
//    last_vertex marks the sixth
//  - front: one register stage that clamps opacity, picks the source rectangle
//    and reduces the angle to quadrant and octant offset
//  - queue of FIFO_DEPTH sprites decouples front from back
//  - back: sin/cos table read, four 24x32 products, corner sums, and four
//    iterative uv dividers running in parallel
//  - sprite rate: set by the vertex channel, which moves one item a cycle
//    while vertex_stall is low; the back computes the next sprite while the
//    current one is being emitted
//  - vertex_stall holds the output register; the back and queue fill up and
//    sprite_stall rises once the queue and front stage are full
//  - reset clears all valid and count state; no clearing pass is needed

module sprite_quad_vertex_setup import sqvs_pkg::*; #(
	parameter int FIFO_DEPTH = SQVS_FIFO_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         sprite_valid,
	output logic         sprite_stall,
	input  sqvs_sprite_t sprite,
	output logic         vertex_valid,
	input  logic         vertex_stall,
	output sqvs_vertex_t vertex
);

	// front to queue
	logic       push;
	sqvs_job_t  job_in;
	logic       full;
	// queue to back
	logic       pop;
	sqvs_job_t  job_out;
	logic       nonempty;
	// compute to emitter
	logic       quad_valid;
	sqvs_quad_t quad;
	logic       emit_ready;
	logic       quad_take;

	sqvs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sprite_valid(sprite_valid),
		.sprite_stall(sprite_stall),
		.sprite(sprite),
		.push(push),
		.job(job_in),
		.full(full)
	);

	sqvs_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(job_in),
		.full(full),
		.pop(pop),
		.dout(job_out),
		.nonempty(nonempty)
	);

	// the emitter copies the corner terms, so compute frees up at hand-off
	assign quad_take = quad_valid & emit_ready;

	sqvs_calc u_calc (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(nonempty),
		.job(job_out),
		.job_pop(pop),
		.quad_valid(quad_valid),
		.quad(quad),
		.quad_take(quad_take)
	);

	sqvs_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.quad_valid(quad_valid),
		.quad(quad),
		.ready(emit_ready),
		.vertex_valid(vertex_valid),
		.vertex_stall(vertex_stall),
		.vertex(vertex)
	);

endmodule

FILE: sv/sqvs_check.sv
// sqvs_check: port level checks on the vertex channel, bound to the top level
// depends on sqvs_pkg and sprite_quad_vertex_setup

module sqvs_check import sqvs_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         vertex_valid,
	input logic         vertex_stall,
	input sqvs_vertex_t vertex
);

	// a stalled vertex stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && vertex_stall |=> vertex_valid && $stable(vertex))
		else $error("vertex changed under stall");

	// drawn sprites always carry clamped, nonzero opacity
	a_opac: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid |-> vertex.vertex_opacity != 15'd0
			&& vertex.vertex_opacity <= 15'(OPACITY_ONE))
		else $error("vertex opacity out of range");

	// the six vertices of a sprite come without gaps and share attributes
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !vertex_stall && !vertex.last_vertex |=> vertex_valid
			&& $stable(vertex.vertex_effect) && $stable(vertex.vertex_opacity))
		else $error("gap or attribute change inside a sprite");

endmodule

bind sprite_quad_vertex_setup sqvs_check u_sqvs_check (
	.clk(clk),
	.arst_n(arst_n),
	.vertex_valid(vertex_valid),
	.vertex_stall(vertex_stall),
	.vertex(vertex)
);

FILE: verif/sprite_quad_vertex_setup_test.sv
// sprite_quad_vertex_setup_test: self-checking bench for the sprite quad vertex setup block
// predicts the six vertices of every drawn sprite and compares them in order
// depends on sqvs_pkg and sprite_quad_vertex_setup
`timescale 1ns / 100ps

module sprite_quad_vertex_setup_test;
	import sqvs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_LEN    = 300;

	logic         clk;
	logic         arst_n;
	logic         sprite_valid;
	logic         sprite_stall;
	sqvs_sprite_t sprite;
	logic         vertex_valid;
	logic         vertex_stall;
	sqvs_vertex_t vertex;

	sqvs_vertex_t pending_vertices[$];
	int           mismatches;
	int           sprites_sent;
	int           sprites_drawn;
	int           vertices_seen;
	int           cycles;

	// idle rates in percent for sender and receiver
	int tx_idle_pct;
	int rx_idle_pct;

	// long receiver hold, requested by toggling hold_req
	bit hold_req;
	bit hold_seen;
	int hold_cnt;

	sprite_quad_vertex_setup dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sprite_valid (sprite_valid),
		.sprite_stall (sprite_stall),
		.sprite       (sprite),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex       (vertex)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// sin and cos in Q30 of 0..45 degrees, truncated taylor series
	task automatic octant_sincos(input longint units, output longint s, output longint c);
		logic [63:0] r, r2, r3, r4, r5, r6, r7, r8, r9;
		r  = 64'(units) * 64'd1171271;
		r2 = (r * r) >> 30;
		r3 = (r2 * r) >> 30;
		r4 = (r2 * r2) >> 30;
		r5 = (r4 * r) >> 30;
		r6 = (r4 * r2) >> 30;
		r7 = (r6 * r) >> 30;
		r8 = (r4 * r4) >> 30;
		r9 = (r8 * r) >> 30;
		s = longint'(r) - longint'(r3 / 6) + longint'(r5 / 120)
			- longint'(r7 / 5040) + longint'(r9 / 362880);
		c = 64'sd1073741824 - longint'(r2 / 2) + longint'(r4 / 24)
			- longint'(r6 / 720) + longint'(r8 / 40320);
	endtask

	task automatic angle_sincos(input longint ang, output longint s, output longint c);
		longint m, q, f, s0, c0;
		m = ang % 5760;
		if (m < 0)
			m += 5760;
		q = m / 1440;
		f = m % 1440;
		if (f <= 720)
			octant_sincos(f, s0, c0);
		else
			octant_sincos(1440 - f, c0, s0);
		case (q)
			0: begin s = s0;  c = c0;  end
			1: begin s = c0;  c = -s0; end
			2: begin s = -s0; c = -c0; end
			default: begin s = -c0; c = s0; end
		endcase
	endtask

	// Q39 to Q8 with round half up and 24 bit saturation
	function automatic logic signed [23:0] q39_to_pixel(input longint v);
		longint t;
		t = (v + 64'sd1073741824) >>> 31;
		if (t > 8388607)
			t = 8388607;
		if (t < -8388608)
			t = -8388608;
		return t[23:0];
	endfunction

	function automatic logic [15:0] edge_to_uv(input longint unsigned e, input longint unsigned dim);
		longint unsigned v;
		if (dim == 0)
			v = e * 64;
		else
			v = (e * 64 + dim / 2) / dim;
		return (v > 65535) ? 16'hFFFF : v[15:0];
	endfunction

	// queue the vertices one sprite should produce
	task automatic predict_vertices(input sqvs_sprite_t s);
		longint cx, cy, w, h, op, sn, cs, lx, ly;
		longint unsigned tw, th, sl, st, sr, sb;
		logic signed [23:0] px[4], py[4];
		logic [15:0] u0, u1, v0, v1;
		logic [14:0] opc;
		sqvs_vertex_t vx;
		int corner;
		cx = s.center_x;
		cy = s.center_y;
		w  = s.sprite_width;
		h  = s.sprite_height;
		op = s.opacity_in;
		if (w <= 0 || h <= 0 || op <= 0)
			return;
		sprites_drawn++;
		opc = (op > 16384) ? 15'd16384 : op[14:0];
		tw = s.texture_size[15:0];
		th = s.texture_size[31:16];
		sl = s.src_left;
		st = s.src_top;
		sr = s.src_right;
		sb = s.src_bottom;
		// empty rectangle means the whole texture
		if (sr <= sl || sb <= st) begin
			sl = 0;
			st = 0;
			sr = tw * 256;
			sb = th * 256;
		end
		u0 = edge_to_uv(sl, tw);
		u1 = edge_to_uv(sr, tw);
		v0 = edge_to_uv(st, th);
		v1 = edge_to_uv(sb, th);
		angle_sincos(longint'(s.rotation_deg), sn, cs);
		for (int k = 0; k < 4; k++) begin
			lx = (k & 1) ? w : -w;
			ly = (k & 2) ? h : -h;
			px[k] = q39_to_pixel(cx * 64'sd2147483648 + lx * cs - ly * sn);
			py[k] = q39_to_pixel(cy * 64'sd2147483648 + lx * sn + ly * cs);
		end
		for (int k = 0; k < 6; k++) begin
			// TL TR BL then TR BR BL
			case (k)
				0: corner = 0;
				1: corner = 1;
				2: corner = 2;
				3: corner = 1;
				4: corner = 3;
				default: corner = 2;
			endcase
			vx.pos_x          = px[corner];
			vx.pos_y          = py[corner];
			vx.tex_u          = (corner & 1) ? u1 : u0;
			vx.tex_v          = (corner & 2) ? v1 : v0;
			vx.vertex_opacity = opc;
			vx.vertex_effect  = s.effect_code;
			vx.last_vertex    = (k == 5);
			pending_vertices = {pending_vertices, vx};
		end
	endtask

	// offer one sprite, called and returning at a rising edge
	task automatic send_sprite(input sqvs_sprite_t s);
		bit taken;
		while ($urandom_range(99) < tx_idle_pct) begin
			sprite_valid <= 1'b0;
			@(posedge clk);
		end
		sprite       <= s;
		sprite_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !sprite_stall;
			if (taken) begin
				predict_vertices(s);
				sprites_sent++;
			end
			@(posedge clk);
		end while (!taken);
	endtask

	function automatic sqvs_sprite_t base_sprite();
		sqvs_sprite_t s;
		s = '0;
		s.sprite_width  = 24'sd2560;
		s.sprite_height = 24'sd1280;
		s.opacity_in    = 16'sd8192;
		s.texture_size  = {16'd64, 16'd128};
		s.src_left      = 24'd256;
		s.src_top       = 24'd512;
		s.src_right     = 24'd4096;
		s.src_bottom    = 24'd8192;
		return s;
	endfunction

	// random sprite; most are drawable with varied content
	function automatic sqvs_sprite_t random_sprite();
		sqvs_sprite_t s;
		int pick;
		s = base_sprite();
		s.center_x      = 24'(($urandom_range(3) == 0) ? $urandom
			: $urandom_range(65535) - 32768);
		s.center_y      = 24'(($urandom_range(3) == 0) ? $urandom
			: $urandom_range(65535) - 32768);
		s.sprite_width  = 24'(($urandom_range(3) == 0) ? ($urandom & 32'h7FFFFF)
			: $urandom_range(40000, 1));
		s.sprite_height = 24'(($urandom_range(3) == 0) ? ($urandom & 32'h7FFFFF)
			: $urandom_range(40000, 1));
		s.rotation_deg  = 16'($urandom);
		s.opacity_in    = 16'(($urandom_range(3) == 0) ? ($urandom & 32'h7FFF)
			: $urandom_range(16384, 1));
		if (s.opacity_in == 16'sd0)
			s.opacity_in = 16'sd1;
		if (s.sprite_width == 24'sd0)
			s.sprite_width = 24'sd1;
		if (s.sprite_height == 24'sd0)
			s.sprite_height = 24'sd1;
		s.effect_code  = 8'($urandom);
		pick = $urandom_range(9);
		if (pick == 0)
			s.texture_size = $urandom;
		else if (pick == 1)
			s.texture_size = $urandom & 32'hFFFF_0000;
		else if (pick == 2)
			s.texture_size = $urandom & 32'h0000_FFFF;
		else
			s.texture_size = {16'($urandom_range(4096, 1)), 16'($urandom_range(4096, 1))};
		s.src_left   = 24'(($urandom_range(4) == 0) ? $urandom : $urandom_range(65535));
		s.src_top    = 24'(($urandom_range(4) == 0) ? $urandom : $urandom_range(65535));
		s.src_right  = 24'(($urandom_range(4) == 0) ? $urandom
			: 32'(s.src_left) + $urandom_range(200000));
		s.src_bottom = 24'(($urandom_range(4) == 0) ? $urandom
			: 32'(s.src_top) + $urandom_range(200000));
		// some sprites that draw nothing
		pick = $urandom_range(19);
		if (pick == 0)
			s.sprite_width = 24'(-$urandom_range(8388608));
		else if (pick == 1)
			s.sprite_height = ($urandom_range(1)) ? 24'sd0 : -24'sd1;
		else if (pick == 2)
			s.opacity_in = 16'(-$urandom_range(32768));
		else if (pick == 3)
			s.opacity_in = 16'sd0;
		return s;
	endfunction

	task automatic test_directed();
		sqvs_sprite_t s;
		int angles[10] = '{0, 720, 1440, 2880, 4320, 5760, -1, 32767, -32768, 719};
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		foreach (angles[i]) begin
			s = base_sprite();
			s.rotation_deg = 16'(angles[i]);
			s.effect_code  = 8'(i * 29);
			send_sprite(s);
		end
		// extreme positions and sizes saturate
		s = base_sprite();
		s.center_x = 24'sh7FFFFF; s.center_y = 24'sh800000;
		s.sprite_width = 24'sh7FFFFF; s.sprite_height = 24'sh7FFFFF;
		s.rotation_deg = 16'sd600; s.effect_code = 8'hFF;
		send_sprite(s);
		s = base_sprite();
		s.sprite_width = 24'sd1; s.sprite_height = 24'sd1;
		s.center_x = 24'sh800000; s.center_y = 24'sh7FFFFF;
		send_sprite(s);
		// non-positive size and opacity draw nothing
		s = base_sprite(); s.sprite_width = 24'sd0; send_sprite(s);
		s = base_sprite(); s.sprite_height = 24'sh800000; send_sprite(s);
		s = base_sprite(); s.opacity_in = 16'sd0; send_sprite(s);
		s = base_sprite(); s.opacity_in = 16'sh8000; send_sprite(s);
		// opacity above one clamps, smallest positive passes
		s = base_sprite(); s.opacity_in = 16'sh7FFF; send_sprite(s);
		s = base_sprite(); s.opacity_in = 16'sd1; send_sprite(s);
		// empty rectangles use the whole texture
		s = base_sprite(); s.src_right = s.src_left; send_sprite(s);
		s = base_sprite(); s.src_bottom = 24'd0; s.texture_size = 32'hFFFF_FFFF; send_sprite(s);
		// zero texture dimensions and uv overflow
		s = base_sprite(); s.texture_size = 32'h0; s.src_right = 24'hFFFFFF;
		s.src_bottom = 24'hFFFFFF; send_sprite(s);
		s = base_sprite(); s.texture_size = 32'h0001_0001; send_sprite(s);
		s = base_sprite(); s.texture_size = 32'h0; s.src_right = 24'd0; send_sprite(s);
	endtask

	task automatic test_random_phase(input int count, input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (count)
			send_sprite(random_sprite());
	endtask

	// receiver holds off for a long stretch while sprites keep coming
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req = !hold_req;
		repeat (14)
			send_sprite(random_sprite());
	endtask

	// receiver stall, with the long hold counted here
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen    <= hold_req;
			hold_cnt     <= HOLD_LEN;
			vertex_stall <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt     <= hold_cnt - 1;
			vertex_stall <= 1'b1;
		end else begin
			vertex_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// outputs move only at rising edges, so the midpoint sample is stable
	always @(negedge clk) begin
		sqvs_vertex_t want;
		if (arst_n && vertex_valid && !vertex_stall) begin
			vertices_seen++;
			if (pending_vertices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected vertex %p", vertex);
			end else begin
				want = pending_vertices.pop_front();
				if (vertex.pos_x !== want.pos_x || vertex.pos_y !== want.pos_y
						|| vertex.tex_u !== want.tex_u || vertex.tex_v !== want.tex_v
						|| vertex.vertex_opacity !== want.vertex_opacity
						|| vertex.vertex_effect !== want.vertex_effect
						|| vertex.last_vertex !== want.last_vertex) begin
					mismatches++;
					if (mismatches <= 10)
						$display("vertex mismatch: expected %p got %p", want, vertex);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int drain;
		arst_n       = 1'b0;
		sprite_valid = 1'b0;
		sprite       = '0;
		vertex_stall = 1'b1;
		hold_req     = 1'b0;
		hold_seen    = 1'b0;
		hold_cnt     = 0;
		cycles       = 0;
		mismatches   = 0;
		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_phase(150, 11, 69);
		test_random_phase(150, 69, 11);
		test_backpressure();
		test_random_phase(113, 0, 0);
		sprite_valid <= 1'b0;

		drain = 0;
		while (pending_vertices.size() != 0 && drain < 100000) begin
			@(posedge clk);
			drain++;
		end
		repeat (30) @(posedge clk);
		if (pending_vertices.size() != 0) begin
			mismatches++;
			$display("%0d vertices never arrived", pending_vertices.size());
		end
		$display("covered %0d sprites (%0d drawn), %0d vertices checked",
			sprites_sent, sprites_drawn, vertices_seen);
		$display("idle mixes: sender light / receiver heavy, reversed, none, plus a long hold");
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
sv/sqvs_pkg.sv
sv/sqvs_front.sv
sv/sqvs_fifo.sv
sv/sqvs_div.sv
sv/sqvs_calc.sv
sv/sqvs_emit.sv
sv/sprite_quad_vertex_setup.sv
sv/sqvs_check.sv
verif/sprite_quad_vertex_setup_test.sv
